[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Each check is clocked on the rising
// edge and is held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fgtb_pkg.sv]
// ----------------------------------------------------------------------------
// fgtb_pkg
// Constants, register indexes and colour helper for the glyph text blitter.
// ----------------------------------------------------------------------------
package fgtb_pkg;

  // Font geometry defaults
  localparam int GLYPH_WIDTH_DEF = 7;
  localparam int GLYPH_LINES_DEF = 12;
  localparam int GLYPH_COUNT_DEF = 96;

  // Fixed field widths
  localparam int PIX_SLOTS   = 7;   // pixels carried per row write
  localparam int PIX_W       = 8;   // bits per pixel
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 96;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Character code of the first glyph
  localparam int CODE_BASE = 32;

  // Fade ramp: fg+5 down to fg+1, then fg+2 upward
  localparam int FADE_START = 5;
  localparam int FADE_TURN  = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 2'd3;

  // Draw modes
  localparam logic [1:0] MODE_OPAQUE      = 2'd0;
  localparam logic [1:0] MODE_OPAQUE_FADE = 2'd1;
  localparam logic [1:0] MODE_TRANS_FADE  = 2'd2;

  // Register reset values
  localparam logic [31:0] FRAME_BASE_RST = 32'd0;
  localparam logic [12:0] STRIDE_RST     = 13'd640;
  localparam logic [11:0] CLIP_RST       = 12'd464;

  // Commands carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Foreground colour of glyph row r
  function automatic logic [7:0] row_colour(input logic [7:0] fg, input logic [3:0] r,
                                            input logic fade);
    logic [7:0] r8;
    r8 = {4'b0, r};
    if (!fade) begin
      return fg;
    end else if (int'(r) < FADE_TURN) begin
      return fg + 8'(FADE_START) - r8;
    end else begin
      return fg + r8 - 8'(2 * FADE_TURN - FADE_START - 2);
    end
  endfunction

endpackage

[src/fixed_glyph_text_blitter_core.sv]
// ----------------------------------------------------------------------------
// fixed_glyph_text_blitter_core
// Bitmap font character generator: loads glyph rows into a one-bit-per-pixel
// store and expands draw requests into GLYPH_LINES frame-buffer row writes.
// ----------------------------------------------------------------------------
// A drawn character passes the setup and run states, the read stage and the
// output register; rows then leave one per cycle while out_tready stays high,
// set by the single read port of the glyph store. No new request is taken until
// the last row has left the read stage; loads and suppressed draws leave the block idle.
// Reset clears the pen, the registers and the pipeline; the glyph store is not
// cleared and holds nothing defined until loaded.
module fixed_glyph_text_blitter_core #(
  parameter int GLYPH_WIDTH = fgtb_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_LINES = fgtb_pkg::GLYPH_LINES_DEF,
  parameter int GLYPH_COUNT = fgtb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // glyph_code[7:0], glyph_row[11:8], row_bits[18:12], first_char[19],
  // start_x[31:20], start_y[43:32], fg_index[51:44], bg_index[59:52]
  input  logic [fgtb_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[0]
  input  logic                              in_tuser,
  // row writes
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // write_address[31:0], row_pixels[87:32], write_mask[94:88]
  output logic [fgtb_pkg::OUT_DATA_W-1:0]   out_tdata,
  // last_row
  output logic                              out_tlast,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fgtb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgtb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_LINES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (GLYPH_LINES > 1) ? $clog2(GLYPH_LINES) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_LINES - 1);
  localparam int SLOTS  = fgtb_pkg::PIX_SLOTS;
  localparam int PW     = fgtb_pkg::PIX_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // Input fields
  logic [7:0]       in_code;
  logic [3:0]       in_row;
  logic [SLOTS-1:0] in_bits;
  logic             in_first;
  logic [11:0]      in_sx;
  logic [11:0]      in_sy;
  logic [7:0]       in_fg;
  logic [7:0]       in_bg;

  assign in_code  = in_tdata[7:0];
  assign in_row   = in_tdata[11:8];
  assign in_bits  = in_tdata[18:12];
  assign in_first = in_tdata[19];
  assign in_sx    = in_tdata[31:20];
  assign in_sy    = in_tdata[43:32];
  assign in_fg    = in_tdata[51:44];
  assign in_bg    = in_tdata[59:52];

  // Configuration registers
  logic [31:0] frame_base_r;
  logic [12:0] stride_r;
  logic [1:0]  mode_r;
  logic [11:0] clip_r;

  // Control and per-draw context
  logic [1:0]        state_r, state_nxt;
  logic [15:0]       pen_r;
  logic [15:0]       x_r;
  logic [11:0]       sy_r;
  logic [7:0]        glyph_r;
  logic [7:0]        fg_r;
  logic [7:0]        bg_r;
  logic              fade_r;
  logic              trans_r;
  logic [ADDR_W-1:0] glyph_base_r;
  logic [31:0]       addr_r;
  logic [ROW_W-1:0]  iss_row_r;

  // Read stage and output register
  logic              s1_valid_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              out_valid_r;
  logic [31:0]       out_addr_r;
  logic [SLOTS*PW-1:0] out_pix_r;
  logic [SLOTS-1:0]  out_mask_r;
  logic              out_last_r;

  // Glyph store
  logic [SLOTS-1:0]  store_mem [DEPTH];
  logic [SLOTS-1:0]  rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              store_we;
  logic [ADDR_W-1:0] store_waddr;

  logic              in_acc;
  logic              is_draw;
  logic              code_ok;
  logic              clipped;
  logic [15:0]       x_cur;
  logic [1:0]        mode_eff;
  logic              s1_adv;
  logic              s1_move;
  logic [24:0]       line_prod;
  logic [7:0]        row_col;
  logic [SLOTS*PW-1:0] pix_c;
  logic [SLOTS-1:0]  mask_c;

  assign cfg_ready = 1'b1;

  // Take a request only when idle and the read stage has drained
  assign in_tready = (state_r == ST_IDLE) && !s1_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign is_draw   = (in_tuser == fgtb_pkg::CMD_DRAW);

  assign mode_eff = (mode_r == fgtb_pkg::MODE_OPAQUE_FADE || mode_r == fgtb_pkg::MODE_TRANS_FADE)
                    ? mode_r : fgtb_pkg::MODE_OPAQUE;
  assign code_ok  = (int'(in_code) >= fgtb_pkg::CODE_BASE) &&
                    (int'(in_code) < fgtb_pkg::CODE_BASE + GLYPH_COUNT);
  assign clipped  = (mode_eff == fgtb_pkg::MODE_TRANS_FADE) && (in_sy > clip_r);
  assign x_cur    = in_first ? {4'b0, in_sx} : pen_r;

  // Load path: write one glyph row when in range
  assign store_we    = in_acc && !is_draw && (int'(in_code) < GLYPH_COUNT) &&
                       (int'(in_row) < GLYPH_LINES);
  assign store_waddr = ADDR_W'(int'(in_code) * GLYPH_LINES + int'(in_row));

  // Issue one row read per cycle while the read stage can move on
  assign s1_adv  = !out_valid_r || out_tready;
  assign s1_move = s1_valid_r && s1_adv;
  assign rd_en   = (state_r == ST_RUN) && (!s1_valid_r || s1_adv);
  assign rd_addr = glyph_base_r + ADDR_W'(iss_row_r);

  assign line_prod = {1'b0, sy_r} * {12'b0, stride_r};

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= in_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_draw && code_ok && !clipped) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (rd_en && iss_row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pen_r        <= 16'd0;
      frame_base_r <= fgtb_pkg::FRAME_BASE_RST;
      stride_r     <= fgtb_pkg::STRIDE_RST;
      mode_r       <= fgtb_pkg::MODE_OPAQUE;
      clip_r       <= fgtb_pkg::CLIP_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      iss_row_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fgtb_pkg::REG_FRAME_BASE:  frame_base_r <= cfg_data;
          fgtb_pkg::REG_LINE_STRIDE: stride_r     <= cfg_data[12:0];
          fgtb_pkg::REG_DRAW_MODE:   mode_r       <= cfg_data[1:0];
          fgtb_pkg::REG_CLIP_LIMIT:  clip_r       <= cfg_data[11:0];
          default: ;
        endcase
      end

      // Advance the pen on every draw, drawn or not
      if (in_acc && is_draw) begin
        pen_r <= x_cur + 16'(GLYPH_WIDTH);
      end

      // Row read counter
      if (state_r == ST_SETUP) begin
        iss_row_r <= '0;
      end else if (rd_en) begin
        iss_row_r <= iss_row_r + ROW_W'(1);
      end

      // Read stage occupancy
      if (rd_en) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      // Output register occupancy
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-draw context and row address
  always_ff @(posedge clk) begin
    if (in_acc && is_draw) begin
      x_r     <= x_cur;
      sy_r    <= in_sy;
      glyph_r <= 8'(int'(in_code) - fgtb_pkg::CODE_BASE);
      fg_r    <= in_fg;
      bg_r    <= in_bg;
      fade_r  <= (mode_eff != fgtb_pkg::MODE_OPAQUE);
      trans_r <= (mode_eff == fgtb_pkg::MODE_TRANS_FADE);
    end
    if (state_r == ST_SETUP) begin
      glyph_base_r <= ADDR_W'(int'(glyph_r) * GLYPH_LINES);
      addr_r       <= frame_base_r + {16'b0, x_r} + {7'b0, line_prod};
    end else if (s1_move) begin
      addr_r <= addr_r + {19'b0, stride_r};
    end
    if (rd_en) begin
      s1_row_r <= iss_row_r;
    end
  end

  // Expand one glyph row into pixels and mask
  assign row_col = fgtb_pkg::row_colour(fg_r, 4'(s1_row_r), fade_r);

  always_comb begin
    pix_c  = '0;
    mask_c = '0;
    for (int a = 0; a < SLOTS; a++) begin
      if (a < GLYPH_WIDTH) begin
        if (rd_data_r[a]) begin
          pix_c[a*PW +: PW] = row_col;
          mask_c[a]         = 1'b1;
        end else if (!trans_r) begin
          pix_c[a*PW +: PW] = bg_r;
          mask_c[a]         = 1'b1;
        end
      end
    end
  end

  // Hold the row write until taken
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_addr_r <= addr_r;
      out_pix_r  <= pix_c;
      out_mask_r <= mask_c;
      out_last_r <= (s1_row_r == LAST_ROW);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mask_r, out_pix_r, out_addr_r};
  assign out_tlast  = out_last_r;

`include "assert_macros.svh"

  `ASSERT_CLK(a_read_only_in_run, clk, rst_n, !rd_en || state_r == ST_RUN, "read outside run")
  `ASSERT_CLK(a_load_when_drained, clk, rst_n, !store_we || (state_r == ST_IDLE && !s1_valid_r), "load in draw")
  `ASSERT_CLK(a_last_row_ends_run, clk, rst_n, !(s1_valid_r && s1_row_r == LAST_ROW) || state_r == ST_IDLE, "late issue")
  `ASSERT_NEXT(a_setup_one_cycle, clk, rst_n, state_r == ST_SETUP, state_r == ST_RUN, "setup did not move to run")

endmodule

[tb/glyph_blit_checker.sv]
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// glyph_blit_checker
// Watches the request, row-write and register channels of the glyph text
// blitter. Keeps its own font store, pen and register copies, expands each
// accepted draw request into the row writes it should produce, and compares
// every row write that leaves the block against the oldest one still due.
// ----------------------------------------------------------------------------
module glyph_blit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [fgtb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [fgtb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fgtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgtb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              rows_pending,
  output int                              rows_checked
);
  import fgtb_pkg::*;

  localparam int GLYPH_WIDTH = GLYPH_WIDTH_DEF;
  localparam int GLYPH_LINES = GLYPH_LINES_DEF;
  localparam int GLYPH_COUNT = GLYPH_COUNT_DEF;
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_LINES;

  // Request fields as packed on in_tdata, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  bg_index;
    logic [7:0]  fg_index;
    logic [11:0] start_y;
    logic [11:0] start_x;
    logic        first_char;
    logic [6:0]  row_bits;
    logic [3:0]  glyph_row;
    logic [7:0]  glyph_code;
  } glyph_request_t;

  typedef struct {
    logic [31:0] address;
    logic [55:0] pixels;
    logic [6:0]  mask;
    logic        last;
  } row_write_t;

  logic [6:0]  font_rows [FONT_DEPTH];
  logic [15:0] pen_x;
  logic [31:0] frame_base;
  logic [12:0] line_stride;
  logic [1:0]  draw_mode;
  logic [11:0] clip_row_limit;
  row_write_t  row_writes_due [$];

  initial begin
    fail_count   = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  // Store a glyph row, or expand a character into its row writes
  task automatic take_request(input logic command, input glyph_request_t req);
    int unsigned glyph;
    logic [15:0] x;
    logic [1:0]  mode;
    logic        fade;
    logic        transparent;
    logic [6:0]  bits;
    logic [7:0]  colour;
    logic [7:0]  pix;
    row_write_t  row;
    if (command == CMD_LOAD) begin
      if (req.glyph_code < GLYPH_COUNT && req.glyph_row < GLYPH_LINES) begin
        font_rows[req.glyph_code * GLYPH_LINES + req.glyph_row] = req.row_bits;
      end
      return;
    end

    // Pen moves on every draw, drawn or not
    if (req.first_char) begin
      pen_x = {4'b0, req.start_x};
    end
    x = pen_x;
    pen_x = pen_x + 16'(GLYPH_WIDTH);

    if (req.glyph_code < CODE_BASE || req.glyph_code >= CODE_BASE + GLYPH_COUNT) begin
      return;
    end
    glyph = req.glyph_code - CODE_BASE;

    // The spare mode code draws as plain opaque
    mode = (draw_mode == MODE_OPAQUE_FADE || draw_mode == MODE_TRANS_FADE) ?
           draw_mode : MODE_OPAQUE;
    fade = (mode != MODE_OPAQUE);
    transparent = (mode == MODE_TRANS_FADE);
    if (transparent && req.start_y > clip_row_limit) begin
      return;
    end

    for (int r = 0; r < GLYPH_LINES; r++) begin
      bits = font_rows[glyph * GLYPH_LINES + r];
      // Fade ramps down from fg+5 to fg+1, then climbs from fg+2
      if (!fade) begin
        colour = req.fg_index;
      end else if (r < FADE_TURN) begin
        colour = req.fg_index + 8'(FADE_START - r);
      end else begin
        colour = req.fg_index + 8'(r + FADE_START - 2 * FADE_TURN + 2);
      end
      row.address = frame_base + 32'(x) + (32'(req.start_y) + 32'(r)) * 32'(line_stride);
      row.pixels  = '0;
      row.mask    = '0;
      for (int a = 0; a < GLYPH_WIDTH && a < PIX_SLOTS; a++) begin
        if (bits[a]) begin
          pix = colour;
          row.mask[a] = 1'b1;
        end else if (transparent) begin
          pix = 8'd0;
        end else begin
          pix = req.bg_index;
          row.mask[a] = 1'b1;
        end
        row.pixels[PIX_W*a +: PIX_W] = pix;
      end
      row.last = (r == GLYPH_LINES - 1);
      row_writes_due.push_back(row);
    end
  endtask

  // Compare one row write against the oldest prediction
  task automatic check_row_write(input logic [OUT_DATA_W-1:0] data, input logic last);
    row_write_t due;
    if (row_writes_due.size() == 0) begin
      $display("%0t: row write with none due, address %h mask %b", $time,
               data[31:0], data[94:88]);
      fail_count++;
      return;
    end
    due = row_writes_due.pop_front();
    rows_checked++;
    if (data[31:0] !== due.address) begin
      $display("%0t: write_address expected %h got %h", $time, due.address, data[31:0]);
      fail_count++;
    end
    if (data[87:32] !== due.pixels) begin
      $display("%0t: row_pixels expected %h got %h", $time, due.pixels, data[87:32]);
      fail_count++;
    end
    if (data[94:88] !== due.mask) begin
      $display("%0t: write_mask expected %b got %b", $time, due.mask, data[94:88]);
      fail_count++;
    end
    if (last !== due.last) begin
      $display("%0t: last_row expected %b got %b", $time, due.last, last);
      fail_count++;
    end
  endtask

  // Follow all three channels at each clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pen_x          = '0;
      frame_base     = FRAME_BASE_RST;
      line_stride    = STRIDE_RST;
      draw_mode      = MODE_OPAQUE;
      clip_row_limit = CLIP_RST;
      row_writes_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_row_write(out_tdata, out_tlast);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_BASE:  frame_base = cfg_data;
          REG_LINE_STRIDE: line_stride = cfg_data[12:0];
          REG_DRAW_MODE:   draw_mode = cfg_data[1:0];
          REG_CLIP_LIMIT:  clip_row_limit = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        take_request(in_tuser, glyph_request_t'(in_tdata));
      end
    end
    rows_pending = row_writes_due.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the glyph text blitter. Loads glyphs, draws
// strings in every draw mode across a range of register settings, and lets
// the checker judge every row write.
// ----------------------------------------------------------------------------
module testbench;
  import fgtb_pkg::*;

  localparam int GLYPH_LINES    = GLYPH_LINES_DEF;
  localparam int GLYPH_COUNT    = GLYPH_COUNT_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CLK_PERIOD     = 10;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 52;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int rows_pending;
  int rows_checked;

  int          cycle_count = 0;
  int          stall_pct = 0;
  int          ready_run = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  int          requests_sent = 0;
  int          ignored_sent = 0;
  int          draws_sent = 0;
  int          settings_used = 0;
  logic [11:0] cur_clip = CLIP_RST;
  bit          row_loaded [GLYPH_COUNT][GLYPH_LINES];
  int          ready_glyphs [$];

  fixed_glyph_text_blitter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  glyph_blit_checker blit_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hold out_tready for short runs, stalling at the phase's rate
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
      ready_run <= $urandom_range(0, 3);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no finish within %0d cycles, %0d row writes still due", $time,
               CYCLE_LIMIT, rows_pending);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(
    input logic [7:0] code, input logic [3:0] row, input logic [6:0] bits,
    input logic first, input logic [11:0] sx, input logic [11:0] sy,
    input logic [7:0] fg, input logic [7:0] bg);
    return {4'b0, bg, fg, sy, sx, first, bits, row, code};
  endfunction

  function automatic logic [7:0] stray_code();
    if ($urandom_range(0, 1)) begin
      return 8'($urandom_range(0, CODE_BASE - 1));
    end
    return 8'($urandom_range(CODE_BASE + GLYPH_COUNT, 255));
  endfunction

  function automatic logic [7:0] loaded_code();
    return 8'(CODE_BASE + ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
  endfunction

  function automatic logic [6:0] random_bits();
    if ($urandom_range(0, 7) == 0) begin
      return {7{1'($urandom)}};
    end
    return 7'($urandom);
  endfunction

  function automatic logic [11:0] random_coordinate();
    if ($urandom_range(0, 3) == 0) begin
      return {12{1'($urandom)}};
    end
    return 12'($urandom);
  endfunction

  // Offer one request, in bursts with random gaps between them (none when steady)
  task automatic send_request(input logic command, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= command;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // Load one glyph row and note which glyphs are now safe to draw
  task automatic load_glyph_row(input int glyph, input int row, input logic [6:0] bits);
    int filled;
    send_request(CMD_LOAD, pack_request(8'(glyph), 4'(row), bits, 1'($urandom),
                 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom)));
    if (glyph < GLYPH_COUNT && row < GLYPH_LINES) begin
      if (!row_loaded[glyph][row]) begin
        row_loaded[glyph][row] = 1'b1;
        filled = 0;
        for (int r = 0; r < GLYPH_LINES; r++) begin
          filled += row_loaded[glyph][r];
        end
        if (filled == GLYPH_LINES) begin
          ready_glyphs.push_back(glyph);
        end
      end
    end else begin
      ignored_sent++;
    end
  endtask

  task automatic load_whole_glyph(input int glyph);
    for (int r = 0; r < GLYPH_LINES; r++) begin
      load_glyph_row(glyph, r, random_bits());
    end
  endtask

  task automatic draw_character(input logic [7:0] code, input logic first,
                                input logic [11:0] sx, input logic [11:0] sy,
                                input logic [7:0] fg, input logic [7:0] bg);
    send_request(CMD_DRAW, pack_request(code, 4'($urandom), 7'($urandom), first,
                 sx, sy, fg, bg));
    draws_sent++;
  endtask

  // A string: pen set on the first character, mostly drawable codes
  task automatic draw_string();
    int          length;
    logic [11:0] sy;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  code;
    length = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       sy = cur_clip;
      1:       sy = cur_clip + 12'd1;
      default: sy = random_coordinate();
    endcase
    fg = 8'($urandom);
    bg = 8'($urandom);
    for (int i = 0; i < length; i++) begin
      code = ($urandom_range(0, 6) == 0) ? stray_code() : loaded_code();
      draw_character(code, (i == 0) || ($urandom_range(0, 15) == 0),
                     random_coordinate(), sy, fg, bg);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers, sometimes with noise above the stride, mode and clip fields
  task automatic program_registers(input logic [31:0] base, input logic [12:0] stride,
                                   input logic [1:0] mode, input logic [11:0] clip);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_register(REG_FRAME_BASE, base);
    write_register(REG_LINE_STRIDE, {junk[31:13], stride});
    write_register(REG_DRAW_MODE, {junk[31:2], mode});
    write_register(REG_CLIP_LIMIT, {junk[31:12], clip});
    cfg_valid <= 1'b0;
    cur_clip = clip;
    settings_used++;
  endtask

  // Drop the request, drain every row write due, then let the pipeline empty
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    int phase_start;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = CMD_LOAD;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_FRAME_BASE;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    stall_pct = 25;

    // Directed: one known glyph, ignored loads, codes at, below and beyond the font
    for (int r = 0; r < GLYPH_LINES; r++) begin
      load_glyph_row(0, r, (r == 0) ? 7'h7F : (r == 1) ? 7'h00 : 7'(r * 37));
    end
    load_glyph_row(GLYPH_COUNT, 0, 7'h7F);
    load_glyph_row(255, 15, 7'h7F);
    // row out of range: must not spill into the next glyph's first row
    load_glyph_row(0, GLYPH_LINES, 7'h00);
    draw_character(8'(CODE_BASE), 1'b1, 12'd0, 12'd0, 8'h00, 8'hFF);
    draw_character(8'(CODE_BASE), 1'b0, 12'hFFF, 12'hFFF, 8'hFF, 8'h00);
    draw_character(8'(CODE_BASE - 1), 1'b0, 12'd0, 12'd0, 8'h11, 8'h22);
    draw_character(8'(CODE_BASE + GLYPH_COUNT), 1'b0, 12'd0, 12'd0, 8'h11, 8'h22);
    draw_character(8'd0, 1'b0, 12'd0, 12'd0, 8'h11, 8'h22);
    draw_character(8'hFF, 1'b0, 12'd0, 12'd0, 8'h11, 8'h22);
    draw_character(8'(CODE_BASE), 1'b1, 12'hFFF, CLIP_RST, 8'h80, 8'h7F);
    wait_for_idle();

    // Fade with wrapping colours and a wrapping address
    program_registers(32'hFFFF_FFFF, 13'd4096, MODE_OPAQUE_FADE, CLIP_RST);
    draw_character(8'(CODE_BASE), 1'b1, 12'd100, 12'd200, 8'hFE, 8'h01);
    draw_character(8'(CODE_BASE), 1'b0, 12'd0, 12'd0, 8'h00, 8'hFF);
    wait_for_idle();

    // Transparent fade: on the clip line, just past it, and well inside
    program_registers(32'h0000_1000, STRIDE_RST, MODE_TRANS_FADE, 12'd100);
    draw_character(8'(CODE_BASE), 1'b1, 12'd7, 12'd100, 8'hFB, 8'h00);
    draw_character(8'(CODE_BASE), 1'b0, 12'd0, 12'd101, 8'h40, 8'h55);
    draw_character(8'(CODE_BASE), 1'b0, 12'd0, 12'd0, 8'h03, 8'hAA);
    wait_for_idle();

    // Spare mode code draws opaque
    program_registers(32'd0, 13'd13, MODE_SPARE, 12'd0);
    draw_character(8'(CODE_BASE), 1'b1, 12'd5, 12'hFFF, 8'd33, 8'd44);
    wait_for_idle();

    // Random phases, each under its own register setting and stall rate
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_registers(FRAME_BASE_RST, STRIDE_RST, MODE_OPAQUE, CLIP_RST);
        1: program_registers(32'hFFFF_FFFF, 13'd4096, MODE_OPAQUE_FADE, 12'hFFF);
        2: program_registers($urandom, 13'd1, MODE_TRANS_FADE, 12'd0);
        3: program_registers($urandom, 13'($urandom_range(1, 4096)), MODE_TRANS_FADE,
                             12'($urandom));
        4: program_registers($urandom, 13'd0, MODE_SPARE, 12'($urandom));
        5: program_registers(32'd0, 13'h1FFF, MODE_TRANS_FADE, 12'hFFF);
        default: program_registers($urandom, 13'($urandom_range(1, 4096)), 2'($urandom),
                                   12'($urandom));
      endcase
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      steady = (p % 4 == 1);
      if (p == 0) begin
        load_whole_glyph(GLYPH_COUNT - 1);
        draw_character(8'(CODE_BASE + GLYPH_COUNT - 1), 1'b1, 12'd64, 12'd32,
                       8'($urandom), 8'($urandom));
      end
      phase_start = requests_sent - ignored_sent;
      while (requests_sent - ignored_sent - phase_start < PHASE_REQUESTS) begin
        pick = $urandom_range(0, 99);
        if (pick < 15 || ready_glyphs.size() == 0) begin
          load_whole_glyph($urandom_range(0, GLYPH_COUNT - 1));
        end else if (pick < 25) begin
          load_glyph_row($urandom_range(0, GLYPH_COUNT - 1),
                         $urandom_range(0, GLYPH_LINES - 1), random_bits());
        end else if (pick < 30) begin
          // noise: loads the block drops, and a lone code outside the font
          if ($urandom_range(0, 1)) begin
            load_glyph_row($urandom_range(GLYPH_COUNT, 255), $urandom_range(0, 15),
                           random_bits());
          end else begin
            load_glyph_row($urandom_range(0, GLYPH_COUNT - 1),
                           $urandom_range(GLYPH_LINES, 15), random_bits());
          end
          draw_character(stray_code(), 1'($urandom), random_coordinate(),
                         random_coordinate(), 8'($urandom), 8'($urandom));
        end else begin
          draw_string();
        end
      end
      wait_for_idle();
    end

    $display("Sent %0d requests (%0d draws, %0d dropped loads) under %0d register settings;",
             requests_sent, draws_sent, ignored_sent, settings_used);
    $display("%0d row writes compared, %0d mismatches.", rows_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
